>>> hw/rtl/cdf_pkg.sv
// ----------------------------------------------------------------------------
// cdf_pkg
// shared types, tap tables and constants of the cascaded decimating fir
// ----------------------------------------------------------------------------
package cdf_pkg;

    localparam int COEF_W = 18;   // q1.17 rom width
    localparam int ROM_FRAC = 17;
    localparam int CNT_W = 7;     // window fill count width

    // filter selection codes
    localparam logic [1:0] SEL_A = 2'd0;  // 13-tap first stage
    localparam logic [1:0] SEL_B = 2'd1;  // 65-tap second stage
    localparam logic [1:0] SEL_C = 2'd2;  // 61-tap single stage

    localparam logic [CNT_W-1:0] TAPS_A = 7'd13;
    localparam logic [CNT_W-1:0] TAPS_B = 7'd65;
    localparam logic [CNT_W-1:0] TAPS_C = 7'd61;

    localparam logic signed [COEF_W-1:0] ROM_A [7] = '{
        18'sd282, 18'sd1367, -18'sd1355, -18'sd7771, 18'sd2869, 18'sd39216, 18'sd61920
    };
    localparam logic signed [COEF_W-1:0] ROM_B [33] = '{
        18'sd67, -18'sd45, -18'sd111, 18'sd4, 18'sd170, 18'sd50, -18'sd251, -18'sd180,
        18'sd296, 18'sd371, -18'sd280, -18'sd631, 18'sd145, 18'sd918, 18'sd153,
        -18'sd1177, -18'sd653, 18'sd1316, 18'sd1364, -18'sd1221, -18'sd2267, 18'sd753,
        18'sd3305, 18'sd263, -18'sd4387, -18'sd2087, 18'sd5402, 18'sd5293, -18'sd6234,
        -18'sd11953, 18'sd6780, 18'sd41049, 18'sd58566
    };
    localparam logic signed [COEF_W-1:0] ROM_C [31] = '{
        -18'sd72, 18'sd63, 18'sd157, 18'sd18, -18'sd216, -18'sd103, 18'sd299, 18'sd287,
        -18'sd316, -18'sd542, 18'sd228, 18'sd851, 18'sd29, -18'sd1151, -18'sd500,
        18'sd1351, 18'sd1208, -18'sd1323, -18'sd2137, 18'sd916, 18'sd3230, 18'sd58,
        -18'sd4390, -18'sd1871, 18'sd5491, 18'sd5103, -18'sd6401, -18'sd11823,
        18'sd7001, 18'sd41002, 18'sd58325
    };

    // mac control from the sequencer
    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctrl_t;

    // result of one window count update
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             phase;
        logic             emit;
    } stage_upd_t;

    function automatic logic [CNT_W-1:0] taps_of(input logic [1:0] sel);
        logic [CNT_W-1:0] t;
        case (sel)
            SEL_A:   t = TAPS_A;
            SEL_B:   t = TAPS_B;
            default: t = TAPS_C;
        endcase
        return t;
    endfunction

    // half-table lookup of a symmetric filter, i is the tap position
    function automatic logic signed [COEF_W-1:0] coef_of(input logic [1:0] sel,
                                                        input logic [CNT_W-1:0] i);
        logic [CNT_W-1:0] taps;
        logic [CNT_W-1:0] half;
        logic [CNT_W-1:0] k;
        logic signed [COEF_W-1:0] c;
        taps = taps_of(sel);
        half = (taps + 7'd1) >> 1;
        k = (i < half) ? i : (taps - 7'd1 - i);
        c = '0;
        case (sel)
            SEL_A:   if (k < 7'd7)  c = ROM_A[k[2:0]];
            SEL_B:   if (k < 7'd33) c = ROM_B[k[5:0]];
            default: if (k < 7'd31) c = ROM_C[k[4:0]];
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/cascaded_decimating_fir_core.sv
// ----------------------------------------------------------------------------
// cascaded_decimating_fir_core
// multistage decimating low-pass fir on one shared mac and window rams
// ----------------------------------------------------------------------------
// sequencing: a word that completes a stage window runs that stage through
//   mac, drain and round over n taps (n = tap count capped at the window
//   depth): 13, then 65 if the second stage fires, in mode 0, or 61 in mode 1;
//   a word that fires no stage leaves the sequencer idle; a new word is taken
//   only in idle, and later while a finished word waits on a stalled output word
// reset: asynchronous active low, clears counts, phases, mode and out valid;
//   window rams are not cleared, counts keep unwritten entries unread
// ----------------------------------------------------------------------------
module cascaded_decimating_fir_core #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_FRAC_BITS = 17,
    parameter int WINDOW_DEPTH = 65
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           block_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int EXT_W = PTR_W + 2;
    localparam int CNT_W = cdf_pkg::CNT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;  // issue one tap per cycle
    localparam logic [1:0] ST_DRAIN = 2'd2;  // let the mac pipe empty
    localparam logic [1:0] ST_ROUND = 2'd3;  // hand result on

    logic [1:0]              state_reg, state_next;
    logic                    band_mode_reg;
    logic [CNT_W-1:0]        cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;
    logic                    ph1_reg, ph1_next, ph2_reg, ph2_next;
    logic [PTR_W-1:0]        wp1_reg, wp1_next, wp2_reg, wp2_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic                    stage2_reg, stage2_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic signed [cdf_pkg::COEF_W-1:0] coef_reg, coef_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_data_reg, out_data_next;

    logic                    in_acc;
    logic [1:0]              sel_cur;
    logic [1:0]              sel1;
    logic [CNT_W-1:0]        n1, n2;
    logic [CNT_W-1:0]        c1, c2;
    logic                    p1, p2;
    logic [PTR_W-1:0]        wp1_inc, wp2_inc;
    cdf_pkg::stage_upd_t     upd1, upd2;
    logic                    ram1_we, ram2_we;
    logic [SAMPLE_WIDTH-1:0] ram1_rdata, ram2_rdata;
    logic signed [SAMPLE_WIDTH-1:0] mac_sample;
    logic signed [SAMPLE_WIDTH-1:0] mac_result;
    logic                    mac_busy;
    cdf_pkg::mac_ctrl_t      mac_ctrl;
    logic                    mac_clear;

    // tap count capped by window depth
    function automatic logic [CNT_W-1:0] cap_taps(input logic [CNT_W-1:0] taps);
        return (WINDOW_DEPTH < int'(taps)) ? CNT_W'(WINDOW_DEPTH) : taps;
    endfunction

    // circular increment of a window pointer
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // oldest of the n newest entries, newest sits at wp
    function automatic logic [PTR_W-1:0] oldest(input logic [PTR_W-1:0] wp,
                                                input logic [CNT_W-1:0] n);
        logic [EXT_W-1:0] w;
        logic [EXT_W-1:0] nm1;
        w   = EXT_W'(wp);
        nm1 = EXT_W'(n) - EXT_W'(1);
        return (w >= nm1) ? PTR_W'(w - nm1) : PTR_W'(w + EXT_W'(WINDOW_DEPTH) - nm1);
    endfunction

    // fill count and decimation phase, emits on full window then every second word
    function automatic cdf_pkg::stage_upd_t stage_step(input logic [CNT_W-1:0] cnt,
                                                        input logic ph,
                                                        input logic [CNT_W-1:0] n);
        cdf_pkg::stage_upd_t u;
        u.cnt   = cnt;
        u.phase = ph;
        u.emit  = 1'b0;
        if (cnt < n)
        begin
            u.cnt = cnt + CNT_W'(1);
            if (u.cnt == n)
            begin
                u.phase = 1'b0;
                u.emit  = 1'b1;
            end
        end
        else
        begin
            u.phase = ~ph;
            u.emit  = ph;
        end
        return u;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // first stage filter depends on mode, second stage always the 65-tap filter, capped at the window depth
    assign sel1    = band_mode_reg ? cdf_pkg::SEL_C : cdf_pkg::SEL_A;
    assign sel_cur = stage2_reg ? cdf_pkg::SEL_B : sel1;
    assign n1      = cap_taps(cdf_pkg::taps_of(sel1));
    assign n2      = cap_taps(cdf_pkg::TAPS_B);

    // block start clears both stages before the word is taken in
    assign c1 = block_start ? '0 : cnt1_reg;
    assign p1 = block_start ? 1'b0 : ph1_reg;
    assign c2 = block_start ? '0 : cnt2_reg;
    assign p2 = block_start ? 1'b0 : ph2_reg;

    assign wp1_inc = ptr_inc(wp1_reg);
    assign wp2_inc = ptr_inc(wp2_reg);
    assign upd1    = stage_step(c1, p1, n1);
    assign upd2    = stage_step(cnt2_reg, ph2_reg, n2);

    always_comb
    begin
        state_next     = state_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        ph1_next       = ph1_reg;
        ph2_next       = ph2_reg;
        wp1_next       = wp1_reg;
        wp2_next       = wp2_reg;
        rd_ptr_next    = rd_ptr_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        stage2_next    = stage2_reg;
        rd_valid_next  = 1'b0;
        coef_next      = coef_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram1_we        = 1'b0;
        ram2_we        = 1'b0;
        mac_clear      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    ram1_we   = 1'b1;
                    wp1_next  = wp1_inc;
                    cnt1_next = upd1.cnt;
                    ph1_next  = upd1.phase;
                    cnt2_next = c2;
                    ph2_next  = p2;
                    if (upd1.emit)
                    begin
                        mac_clear   = 1'b1;
                        n_next      = n1;
                        idx_next    = '0;
                        rd_ptr_next = oldest(wp1_inc, n1);
                        stage2_next = 1'b0;
                        state_next  = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                rd_valid_next = 1'b1;
                coef_next     = cdf_pkg::coef_of(sel_cur, idx_reg);
                rd_ptr_next   = ptr_inc(rd_ptr_reg);
                idx_next      = idx_reg + CNT_W'(1);
                if (idx_reg == n_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (!stage2_reg && !band_mode_reg)
                begin
                    // pass first stage output into the second window
                    ram2_we   = 1'b1;
                    wp2_next  = wp2_inc;
                    cnt2_next = upd2.cnt;
                    ph2_next  = upd2.phase;
                    if (upd2.emit)
                    begin
                        mac_clear   = 1'b1;
                        n_next      = n2;
                        idx_next    = '0;
                        rd_ptr_next = oldest(wp2_inc, n2);
                        stage2_next = 1'b1;
                        state_next  = ST_MAC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mac_result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_mode_reg <= 1'b0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            ph1_reg       <= 1'b0;
            ph2_reg       <= 1'b0;
            wp1_reg       <= '0;
            wp2_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stage2_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                band_mode_reg <= cfg_wdata;
            end
            cnt1_reg      <= cnt1_next;
            cnt2_reg      <= cnt2_next;
            ph1_reg       <= ph1_next;
            ph2_reg       <= ph2_next;
            wp1_reg       <= wp1_next;
            wp2_reg       <= wp2_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            stage2_reg    <= stage2_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg   <= rd_ptr_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        coef_reg     <= coef_next;
        out_data_reg <= out_data_next;
    end

    // first window, written by input words
    cdf_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(WINDOW_DEPTH)
    ) u_win1 (
        .clk  (clk),
        .we   (ram1_we),
        .waddr(wp1_inc),
        .wdata(sample_in),
        .raddr(rd_ptr_reg),
        .rdata(ram1_rdata)
    );

    // second window, written by first stage results
    cdf_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(WINDOW_DEPTH)
    ) u_win2 (
        .clk  (clk),
        .we   (ram2_we),
        .waddr(wp2_inc),
        .wdata(mac_result),
        .raddr(rd_ptr_reg),
        .rdata(ram2_rdata)
    );

    assign mac_sample          = stage2_reg ? ram2_rdata : ram1_rdata;
    assign mac_ctrl.clear      = mac_clear;
    assign mac_ctrl.data_valid = rd_valid_reg;

    cdf_mac #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .sample  (mac_sample),
        .coef_q17(coef_reg),
        .busy    (mac_busy),
        .result  (mac_result)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

>>> hw/rtl/cdf_ram.sv
// ----------------------------------------------------------------------------
// cdf_ram
// generic simple dual-port ram, one write and one registered read
// ----------------------------------------------------------------------------
module cdf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/cdf_mac.sv
// ----------------------------------------------------------------------------
// cdf_mac
// shared multiply-accumulate unit with round and saturate of the sum
// ----------------------------------------------------------------------------
module cdf_mac #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEFF_FRAC_BITS = 17
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cdf_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    input  logic signed [cdf_pkg::COEF_W-1:0]    coef_q17,
    output logic                                 busy,
    output logic signed [SAMPLE_WIDTH-1:0]       result
);

    localparam int SH_UP = (COEFF_FRAC_BITS >= cdf_pkg::ROM_FRAC) ?
                           COEFF_FRAC_BITS - cdf_pkg::ROM_FRAC : 0;
    localparam int SH_DN = (COEFF_FRAC_BITS < cdf_pkg::ROM_FRAC) ?
                           cdf_pkg::ROM_FRAC - COEFF_FRAC_BITS : 0;
    localparam int CW = cdf_pkg::COEF_W + SH_UP;
    localparam int PROD_W = SAMPLE_WIDTH + CW;
    localparam int ACC_W = PROD_W + 8;
    localparam int RW = cdf_pkg::COEF_W + 1;

    logic signed [RW-1:0]     coef_rnd;
    logic signed [CW-1:0]     coef_scaled;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_shr;
    logic signed [ACC_W-1:0]  sat_hi;
    logic signed [ACC_W-1:0]  sat_lo;

    // coefficient rescale: exact left shift or round-half-up right shift
    always_comb
    begin
        coef_rnd = RW'(coef_q17) + RW'((1 << SH_DN) >> 1);
        if (SH_DN == 0)
        begin
            coef_scaled = CW'(coef_q17) <<< SH_UP;
        end
        else
        begin
            coef_scaled = CW'(coef_rnd >>> SH_DN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sample) * PROD_W'(coef_scaled);
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up, floor shift, saturate
    always_comb
    begin
        acc_sum = acc_reg + (ACC_W'(1) <<< (COEFF_FRAC_BITS - 1));
        acc_shr = acc_sum >>> COEFF_FRAC_BITS;
        sat_hi  = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
        sat_lo  = -(ACC_W'(1) <<< (SAMPLE_WIDTH - 1));
        if (acc_shr > sat_hi)
        begin
            result = SAMPLE_WIDTH'(sat_hi);
        end
        else if (acc_shr < sat_lo)
        begin
            result = SAMPLE_WIDTH'(sat_lo);
        end
        else
        begin
            result = SAMPLE_WIDTH'(acc_shr);
        end
    end

    assign busy = prod_valid_reg;

endmodule

>>> hw/rtl/cdf_checker.sv
// ----------------------------------------------------------------------------
// cdf_checker
// port-level checks on the cascaded decimating fir core
// ----------------------------------------------------------------------------
module cdf_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    block_start,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] sample_out
);

    // a stalled output word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out))
        else $error("output word changed while stalled");

    // results come only from a busy sequencer
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output word appeared while idle");

    // a block start word never fills a window
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && block_start |=> !$rose(out_valid))
        else $error("output word right after block start");

endmodule

bind cascaded_decimating_fir_core cdf_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .block_start(block_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);
